// File: rtl/pdtq_pkg.sv
// pdtq_pkg: types, codes and defaults for the preemptive deferred task queue
// no dependencies; imported by the top level, its checker and the test bench
`timescale 1ns / 1ps

package pdtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NEST_DEPTH_DEF  = 16;

  // width of the fixed low part of the result beat (status up to grant_priority)
  localparam int OUT_FIX_W = 76;
  localparam int IN_W      = 72;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_FINISH   = 2'd2,
    OP_CLEAR    = 2'd3
  } pdtq_op_t;

  typedef enum logic [2:0] {
    STAT_OK   = 3'd0,
    STAT_NULL = 3'd1,
    STAT_FULL = 3'd2,
    STAT_NONE = 3'd3,
    STAT_IDLE = 3'd4,
    STAT_OVER = 3'd5
  } pdtq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_STEP,
    S_INS_CMP,
    S_DSP_EVAL,
    S_FIN_EVAL,
    S_EMIT
  } pdtq_state_t;

  typedef struct packed {
    logic [31:0] entry;
    logic [31:0] argument;
    logic [7:0]  prio;
  } pdtq_slot_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] prio;
  } pdtq_frame_t;

endpackage

// File: rtl/preemptive_deferred_task_queue.sv
// preemptive_deferred_task_queue: priority task queue with preemption check and nesting stack
// depends on pdtq_pkg; queue and nesting stack are synchronous memories inside this module
`timescale 1ns / 1ps

// usage
// - input beats carry one command: in_tuser selects add, dispatch, finish or clear,
//   in_tdata carries the task (entry handle, argument, priority) for an add
// - every command returns exactly one result beat on out_*: status, the granted task
//   (zero when nothing is granted), the queue fill and the running priority afterwards
// - the queue is a circular buffer in one memory; an add walks back from the tail,
//   moving lower-priority tasks up one slot per cycle, so equal priorities keep order
// - a dispatch reads the head from the queue memory and pushes the preempted
//   running state on the nesting stack memory; a finish reads it back
// - a command settled at accept (a reject, a clear, a finish with an empty stack) goes
//   straight to the result stage; dispatch and finish pass an evaluate state after the
//   memory read, and an add walks back over the queue memory, one step per moved task;
//   the insert walk over the queue memory sets the worst case
// - one command is in flight at a time; the next is taken once its result sits in the
//   output register, even while the receiver has not taken that result yet
// - a stalled receiver holds the result beat; a further result waits inside the block
//   and in_tready stays low until it can be handed over
// - reset empties the queue, the stack and the running state; no clearing pass is needed
//   since only written slots are ever read

module preemptive_deferred_task_queue
  import pdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NEST_DEPTH  = NEST_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W = ((OUT_FIX_W + CNT_W + 9 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // command channel
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // task_entry[31:0], task_argument[63:32], task_priority[71:64]
  input  logic [1:0]       in_tuser,   // op[1:0]
  // result channel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status[2:0], granted, grant_entry, grant_argument,
                                       // grant_priority, queue_count, running_valid,
                                       // running_priority, zero fill
);

  localparam int QIW   = $clog2(QUEUE_DEPTH);
  localparam int NIW   = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int DEP_W = $clog2(NEST_DEPTH + 1);

  // state and control registers
  pdtq_state_t        state_r, state_nxt;
  logic [QIW-1:0]     head_r, head_nxt;     // physical slot of the queue head
  logic [CNT_W-1:0]   count_r, count_nxt;   // tasks waiting
  logic [DEP_W-1:0]   depth_r, depth_nxt;   // nesting stack fill
  logic               act_v_r, act_v_nxt;
  logic [7:0]         act_pri_r, act_pri_nxt;
  logic               out_valid_r, out_valid_nxt;

  // working registers of the insert walk and the pending result
  logic [QIW-1:0]     ptr_r, ptr_nxt;       // hole slot of the insert walk
  logic [CNT_W-1:0]   rem_r, rem_nxt;       // tasks still ahead of the hole
  pdtq_slot_t         new_r, new_nxt;
  pdtq_status_t       res_status_r, res_status_nxt;
  logic               res_grant_r, res_grant_nxt;
  pdtq_slot_t         res_slot_r, res_slot_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  // queue memory ports
  pdtq_slot_t         qmem [QUEUE_DEPTH];
  logic               q_we;
  logic [QIW-1:0]     q_waddr, q_raddr;
  pdtq_slot_t         q_wdata, q_rdata_r;

  // nesting stack memory ports
  pdtq_frame_t        smem [NEST_DEPTH];
  logic               s_we;
  logic [NIW-1:0]     s_waddr, s_raddr;
  pdtq_frame_t        s_wdata, s_rdata_r;

  logic [QIW:0]       tail_sum;
  logic [QIW-1:0]     tail_idx;
  logic [DEP_W-1:0]   depth_m1;
  pdtq_op_t           in_op;

  function automatic logic [QIW-1:0] prev_idx(input logic [QIW-1:0] p);
    if (p == '0) begin
      prev_idx = QIW'(QUEUE_DEPTH - 1);
    end else begin
      prev_idx = p - 1'b1;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata_r <= qmem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata_r <= smem[s_raddr];
  end

  assign in_op    = pdtq_op_t'(in_tuser);
  assign tail_sum = (QIW+1)'(head_r) + (QIW+1)'(count_r);
  assign tail_idx = (tail_sum >= (QIW+1)'(QUEUE_DEPTH)) ?
                    QIW'(tail_sum - (QIW+1)'(QUEUE_DEPTH)) : tail_sum[QIW-1:0];
  assign depth_m1 = depth_r - 1'b1;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    depth_nxt      = depth_r;
    act_v_nxt      = act_v_r;
    act_pri_nxt    = act_pri_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_grant_nxt  = res_grant_r;
    res_slot_nxt   = res_slot_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;

    q_we    = 1'b0;
    q_waddr = ptr_r;
    q_wdata = new_r;
    q_raddr = head_r;
    s_we    = 1'b0;
    s_waddr = depth_r[NIW-1:0];
    s_wdata = '{valid: act_v_r, prio: act_pri_r};
    s_raddr = depth_m1[NIW-1:0];

    // receiver takes the held beat
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_grant_nxt  = 1'b0;
          res_slot_nxt   = '0;
          res_status_nxt = STAT_OK;
          state_nxt      = S_EMIT;
          case (in_op)
            OP_ADD: begin
              new_nxt = '{entry: in_tdata[31:0], argument: in_tdata[63:32],
                          prio: in_tdata[71:64]};
              if (in_tdata[31:0] == 32'd0) begin
                res_status_nxt = STAT_NULL;
              end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                res_status_nxt = STAT_FULL;
              end else begin
                ptr_nxt   = tail_idx;
                rem_nxt   = count_r;
                state_nxt = S_INS_STEP;
              end
            end
            OP_DISPATCH: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_NONE;
              end else begin
                q_raddr   = head_r;
                state_nxt = S_DSP_EVAL;
              end
            end
            OP_FINISH: begin
              if (!act_v_r) begin
                res_status_nxt = STAT_IDLE;
              end else if (depth_r == '0) begin
                act_v_nxt   = 1'b0;
                act_pri_nxt = 8'd0;
              end else begin
                s_raddr   = depth_m1[NIW-1:0];
                state_nxt = S_FIN_EVAL;
              end
            end
            default: begin
              count_nxt   = '0;
              depth_nxt   = '0;
              act_v_nxt   = 1'b0;
              act_pri_nxt = 8'd0;
            end
          endcase
        end
      end

      S_INS_STEP: begin
        if (rem_r == '0) begin
          // hole reached its place
          q_we           = 1'b1;
          q_waddr        = ptr_r;
          q_wdata        = new_r;
          count_nxt      = count_r + 1'b1;
          res_status_nxt = STAT_OK;
          state_nxt      = S_EMIT;
        end else begin
          q_raddr   = prev_idx(ptr_r);
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        if (new_r.prio > q_rdata_r.prio) begin
          // move the lower task up into the hole, hole steps toward the head
          q_we    = 1'b1;
          q_waddr = ptr_r;
          q_wdata = q_rdata_r;
          ptr_nxt = prev_idx(ptr_r);
          rem_nxt = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_INS_STEP;
          end else begin
            q_raddr = prev_idx(prev_idx(ptr_r));
          end
        end else begin
          q_we           = 1'b1;
          q_waddr        = ptr_r;
          q_wdata        = new_r;
          count_nxt      = count_r + 1'b1;
          res_status_nxt = STAT_OK;
          state_nxt      = S_EMIT;
        end
      end

      S_DSP_EVAL: begin
        state_nxt = S_EMIT;
        if (act_v_r && (q_rdata_r.prio <= act_pri_r)) begin
          res_status_nxt = STAT_NONE;
        end else if (depth_r == DEP_W'(NEST_DEPTH)) begin
          res_status_nxt = STAT_OVER;
        end else begin
          s_we           = 1'b1;
          s_waddr        = depth_r[NIW-1:0];
          s_wdata        = '{valid: act_v_r, prio: act_pri_r};
          depth_nxt      = depth_r + 1'b1;
          act_v_nxt      = 1'b1;
          act_pri_nxt    = q_rdata_r.prio;
          head_nxt       = (head_r == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt      = count_r - 1'b1;
          res_status_nxt = STAT_OK;
          res_grant_nxt  = 1'b1;
          res_slot_nxt   = q_rdata_r;
        end
      end

      S_FIN_EVAL: begin
        depth_nxt      = depth_m1;
        act_v_nxt      = s_rdata_r.valid;
        act_pri_nxt    = s_rdata_r.valid ? s_rdata_r.prio : 8'd0;
        res_status_nxt = STAT_OK;
        state_nxt      = S_EMIT;
      end

      S_EMIT: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({act_pri_r, act_v_r, count_r, res_slot_r.prio,
                                  res_slot_r.argument, res_slot_r.entry, res_grant_r,
                                  res_status_r});
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      depth_r     <= '0;
      act_v_r     <= 1'b0;
      act_pri_r   <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      depth_r     <= depth_nxt;
      act_v_r     <= act_v_nxt;
      act_pri_r   <= act_pri_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    rem_r        <= rem_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_grant_r  <= res_grant_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// File: rtl/pdtq_checker.sv
// pdtq_checker: port-level assertions for the preemptive deferred task queue
// depends on pdtq_pkg; bound to preemptive_deferred_task_queue at the end of this file
`timescale 1ns / 1ps

module pdtq_checker
  import pdtq_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_FIX_W-1:0] out_low
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_low))
    else $error("result beat changed while stalled");

  // a grant always reports ok
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_low[3] |-> out_low[2:0] == STAT_OK)
    else $error("grant with error status");

  // no grant means zero task fields
  a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_low[3] |-> out_low[OUT_FIX_W-1:4] == '0)
    else $error("task fields set without grant");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_low[2:0] <= STAT_OVER)
    else $error("status code out of range");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while busy");

endmodule

bind preemptive_deferred_task_queue pdtq_checker u_pdtq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_low    (out_tdata[pdtq_pkg::OUT_FIX_W-1:0])
);

// File: tb/sv/preemptive_deferred_task_queue_test.sv
// preemptive_deferred_task_queue_test: self-checking bench for the task queue, one command per
// beat, random idling on both channels; depends on pdtq_pkg and the preemptive_deferred_task_queue rtl
`timescale 1ns / 1ps

module preemptive_deferred_task_queue_test
  import pdtq_pkg::*;
();

  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int NEST_DEPTH  = NEST_DEPTH_DEF;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_W = ((OUT_FIX_W + CNT_W + 9 + 7) / 8) * 8;

  // one command as it goes onto the command channel
  typedef struct {
    pdtq_op_t    op;
    logic [31:0] entry;
    logic [31:0] argument;
    logic [7:0]  prio;
  } task_cmd_t;

  // result beat layout, last member sits in the lowest bits
  typedef struct packed {
    logic [7:0]       running_priority;
    logic             running_valid;
    logic [CNT_W-1:0] queue_count;
    logic [7:0]       grant_priority;
    logic [31:0]      grant_argument;
    logic [31:0]      grant_entry;
    logic             granted;
    logic [2:0]       status;
  } sched_result_t;

  localparam int RES_W = $bits(sched_result_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;   // task_entry, task_argument, task_priority
  logic [1:0] in_tuser = '0;        // op
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;      // status, granted, grant_entry, grant_argument,
                                    // grant_priority, queue_count, running_valid,
                                    // running_priority, zero fill

  preemptive_deferred_task_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NEST_DEPTH (NEST_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // scheduler state mirror: sorted waiting list, running task, preemption stack
  // ---------------------------------------------------------------------------
  pdtq_slot_t  waiting_tasks[QUEUE_DEPTH];
  pdtq_frame_t preempted_frames[NEST_DEPTH];
  int unsigned waiting_n = 0;
  int unsigned nest_n = 0;
  logic        run_valid = 1'b0;
  logic [7:0]  run_prio = '0;

  task_cmd_t     cmd_backlog[$];        // commands not yet on the bus
  sched_result_t expected_results[$];   // predicted beats in accept order
  task_cmd_t     on_bus;                // command currently offered
  int unsigned   accepted_n = 0;
  int unsigned   results_n = 0;
  int unsigned   mismatch_n = 0;
  int unsigned   gap_left = 0;
  int unsigned   stall_left = 0;
  bit            tail_phase = 1'b0;     // no idling once the backlog runs low

  // applies one command to the mirror and returns the beat it should produce
  function automatic sched_result_t step_scheduler(task_cmd_t c);
    sched_result_t r;
    int unsigned   pos;
    bit            found;
    r = '0;
    r.status = STAT_OK;
    case (c.op)
      OP_ADD: begin
        if (c.entry == '0) begin
          r.status = STAT_NULL;
        end else if (waiting_n >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // insert behind every task of equal or higher priority
          pos = waiting_n;
          found = 1'b0;
          for (int k = 0; k < waiting_n; k++) begin
            if (!found && c.prio > waiting_tasks[k].prio) begin
              pos = k;
              found = 1'b1;
            end
          end
          for (int k = waiting_n; k > pos; k--) waiting_tasks[k] = waiting_tasks[k-1];
          waiting_tasks[pos] = '{entry: c.entry, argument: c.argument, prio: c.prio};
          waiting_n++;
        end
      end
      OP_DISPATCH: begin
        if (waiting_n == 0) begin
          r.status = STAT_NONE;
        end else if (run_valid && waiting_tasks[0].prio <= run_prio) begin
          // head does not strictly outrank the running task
          r.status = STAT_NONE;
        end else if (nest_n >= NEST_DEPTH) begin
          r.status = STAT_OVER;
        end else begin
          preempted_frames[nest_n] = '{valid: run_valid, prio: run_prio};
          nest_n++;
          r.granted = 1'b1;
          r.grant_entry = waiting_tasks[0].entry;
          r.grant_argument = waiting_tasks[0].argument;
          r.grant_priority = waiting_tasks[0].prio;
          run_valid = 1'b1;
          run_prio = waiting_tasks[0].prio;
          for (int k = 1; k < waiting_n; k++) waiting_tasks[k-1] = waiting_tasks[k];
          waiting_n--;
        end
      end
      OP_FINISH: begin
        if (!run_valid) begin
          r.status = STAT_IDLE;
        end else if (nest_n == 0) begin
          // running with nothing saved: drop back to idle
          run_valid = 1'b0;
          run_prio = '0;
        end else begin
          nest_n--;
          run_valid = preempted_frames[nest_n].valid;
          run_prio = run_valid ? preempted_frames[nest_n].prio : 8'd0;
        end
      end
      default: begin
        waiting_n = 0;
        nest_n = 0;
        run_valid = 1'b0;
        run_prio = '0;
      end
    endcase
    r.queue_count = CNT_W'(waiting_n);
    r.running_valid = run_valid;
    r.running_priority = run_valid ? run_prio : 8'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(pdtq_op_t op, logic [31:0] ent, logic [31:0] arg, logic [7:0] pri);
    task_cmd_t c;
    c.op = op;
    c.entry = ent;
    c.argument = arg;
    c.prio = pri;
    cmd_backlog.push_back(c);
  endtask

  // unused task fields carry random bits too, the block must ignore them
  task automatic push_ctl(pdtq_op_t op);
    push_cmd(op, $urandom, $urandom, 8'($urandom));
  endtask

  // mostly adds and dispatches, priorities often from a narrow band to get ties
  task automatic push_mix(int unsigned n);
    int unsigned pick;
    logic [31:0] ent;
    logic [7:0]  pri;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      ent = ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom);
      pri = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(60, 63));
      if (pick < 45) push_cmd(OP_ADD, ent, $urandom, pri);
      else if (pick < 72) push_ctl(OP_DISPATCH);
      else if (pick < 98) push_ctl(OP_FINISH);
      else push_ctl(OP_CLEAR);
    end
  endtask

  // fill past full with a few priority levels, then drain by dispatch/finish pairs
  task automatic push_fill_drain();
    push_ctl(OP_CLEAR);
    for (int i = 0; i <= QUEUE_DEPTH; i++)
      push_cmd(OP_ADD, 32'($urandom_range(1, 32'hffff_ffff)), $urandom, 8'($urandom_range(0, 3)));
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      push_ctl(OP_DISPATCH);
      push_ctl(OP_FINISH);
    end
  endtask

  // rising priorities each preempt the last until the nesting stack overflows
  task automatic push_ladder();
    int unsigned base;
    base = $urandom_range(0, 255 - NEST_DEPTH);
    push_ctl(OP_CLEAR);
    for (int i = 0; i <= NEST_DEPTH; i++) begin
      push_cmd(OP_ADD, 32'($urandom_range(1, 32'hffff_ffff)), $urandom, 8'(base + i));
      push_ctl(OP_DISPATCH);
    end
    push_ctl(OP_DISPATCH);
    for (int i = 0; i <= NEST_DEPTH + 1; i++) push_ctl(OP_FINISH);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatch_n++;
    end
  endtask

  task automatic check_result(logic [OUT_W-1:0] beat);
    sched_result_t want;
    sched_result_t got;
    got = sched_result_t'(beat[RES_W-1:0]);
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result beat, expected none actual %0h", $time, beat);
      mismatch_n++;
    end else begin
      want = expected_results.pop_front();
      cmp_field("status", 32'(want.status), 32'(got.status));
      cmp_field("granted", 32'(want.granted), 32'(got.granted));
      cmp_field("grant_entry", want.grant_entry, got.grant_entry);
      cmp_field("grant_argument", want.grant_argument, got.grant_argument);
      cmp_field("grant_priority", 32'(want.grant_priority), 32'(got.grant_priority));
      cmp_field("queue_count", 32'(want.queue_count), 32'(got.queue_count));
      cmp_field("running_valid", 32'(want.running_valid), 32'(got.running_valid));
      cmp_field("running_priority", 32'(want.running_priority), 32'(got.running_priority));
      cmp_field("zero fill", 32'd0, 32'(beat[OUT_W-1:RES_W]));
    end
    results_n++;
  endtask

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // command driver: offers backlog beats, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= OP_ADD;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(step_scheduler(on_bus));
        accepted_n++;
      end
      tail_phase = cmd_backlog.size() < 150;
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!tail_phase && (accepted_n % 200) < 120 && $urandom_range(0, 3) == 0) begin
          // idle burst, this one included; gap_left counts the idle slots still to come
          gap_left = $urandom_range(0, 4);
          in_tvalid <= 1'b0;
        end else begin
          on_bus = cmd_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {on_bus.prio, on_bus.argument, on_bus.entry};
          in_tuser <= on_bus.op;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor with receiver stall bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!tail_phase && (results_n % 256) < 160 && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned queued_n;
    int unsigned pick;

    // directed: idle finish, empty dispatch, null entry, field extremes, ties,
    // blocked dispatch, dispatch from idle and unwinding, clear
    push_cmd(OP_FINISH, '0, '0, '0);
    push_cmd(OP_DISPATCH, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
    push_cmd(OP_ADD, 32'd0, 32'hffff_ffff, 8'hff);
    push_cmd(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
    push_cmd(OP_ADD, 32'h0000_0001, 32'h0000_0000, 8'h00);
    push_cmd(OP_ADD, 32'h8000_0000, 32'h5555_aaaa, 8'h00);
    push_cmd(OP_ADD, 32'haaaa_5555, 32'h8000_0001, 8'h80);
    push_cmd(OP_DISPATCH, '0, '0, '0);
    push_cmd(OP_DISPATCH, '0, '0, '0);
    push_cmd(OP_ADD, 32'h1234_5678, 32'h9abc_def0, 8'hff);
    push_cmd(OP_DISPATCH, '0, '0, '0);
    push_cmd(OP_FINISH, '0, '0, '0);
    push_cmd(OP_DISPATCH, '0, '0, '0);
    push_cmd(OP_FINISH, '0, '0, '0);
    push_cmd(OP_FINISH, '0, '0, '0);
    push_cmd(OP_FINISH, '0, '0, '0);
    push_cmd(OP_DISPATCH, '0, '0, '0);
    push_cmd(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
    push_cmd(OP_DISPATCH, '0, '0, '0);
    push_cmd(OP_FINISH, '0, '0, '0);

    // random part: free mixes plus full-queue and nesting-overflow sequences
    while (cmd_backlog.size() < 1720) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) push_ladder();
      else if (pick == 1) push_fill_drain();
      else push_mix($urandom_range(20, 60));
    end
    queued_n = cmd_backlog.size();

    // all accepted and answered, then quiet for longer than the slowest insert walk
    while (accepted_n < queued_n || expected_results.size() > 0) @(negedge clk);
    repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);

    if (mismatch_n == 0) begin
      $display("preemptive_deferred_task_queue verification clean");
    end else begin
      $display("preemptive_deferred_task_queue verification failed");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("preemptive_deferred_task_queue verification failed");
    $finish;
  end

endmodule
